### hdl/activation_function_unit_defines.svh
// Assertion macros used by the activation unit checker.
// No dependencies; every user supplies clk_i and rst_ni in scope.
`ifndef ACTIVATION_FUNCTION_UNIT_DEFINES_SVH
`define ACTIVATION_FUNCTION_UNIT_DEFINES_SVH

// Checked at every rising edge outside reset.
`define AFU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every rising edge, reset included.
`define AFU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/afu_pkg.sv
// Types, constants, rounding and clamping helpers of the activation function unit.
// No dependencies.
package afu_pkg;

  typedef enum logic [1:0] {
    MODE_RELU    = 2'd0,
    MODE_GELU    = 2'd1,
    MODE_SIGMOID = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e mode;
    logic  last;
    logic  gpos;
    logic  gneg;
  } meta_t;

  localparam int IFRAC    = 28;
  localparam int LOG2_SH  = 48;
  localparam int QUOT_W   = 29;

  localparam logic signed [63:0] RND_HALF   = 64'sd134217728;
  localparam logic signed [63:0] LOG2_RND   = 64'sd140737488355328;
  localparam logic signed [63:0] EXP_LIM_Q  = 64'sd23723322368;
  localparam logic signed [63:0] GELU_LIM_Q = 64'sd2147483648;
  localparam logic signed [21:0] LOG2E_Q20  = 22'sd1512775;
  localparam logic signed [28:0] LN2_HI_Q   = 29'sd186122240;
  localparam logic signed [17:0] LN2_LO_Q   = -18'sd56961;
  localparam logic signed [24:0] GELU_K_Q   = 25'sd12003091;
  localparam logic signed [29:0] TWO_SQRT_2_PI_Q = 30'sd428361012;
  localparam logic signed [31:0] ONE_Q      = 32'sd268435456;

  localparam logic signed [31:0] POLY_Q [6] = '{
    32'sd53353, 32'sd375326, 32'sd2236994,
    32'sd11184577, 32'sd44739239, 32'sd134217731
  };

  // Q.28 product: add half an LSB, then floor.
  function automatic logic signed [63:0] rnd_q(input logic signed [63:0] p);
    return (p + RND_HALF) >>> IFRAC;
  endfunction

  // Clamp an exponent argument to the supported range.
  function automatic logic signed [35:0] clamp_exp(input logic signed [63:0] a);
    logic signed [63:0] c;
    c = a;
    if (a > EXP_LIM_Q) begin
      c = EXP_LIM_Q;
    end else if (a < -EXP_LIM_Q) begin
      c = -EXP_LIM_Q;
    end
    return c[35:0];
  endfunction

endpackage

### hdl/afu_in_if.sv
// Input channel of the activation unit: valid/ready plus sample and last.
// No dependencies.
interface afu_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample;
  logic                         last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

### hdl/afu_out_if.sv
// Output channel of the activation unit: valid/ready plus result and last_out.
// No dependencies.
interface afu_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result;
  logic                         last_out;

  modport source (output valid, result, last_out, input ready);
  modport sink   (input valid, result, last_out, output ready);
endinterface

### hdl/activation_function_unit.sv
// Activation function unit: ReLU, tanh-form GELU or sigmoid on a fixed-point stream.
// One item per cycle is accepted unless a held result stalls the pipeline.
// The latency is set mostly by the 29-stage restoring divider, one quotient bit per stage.
// A full output register that is not taken stalls every stage at once; nothing is lost.
// rst_ni clears the valid bits and the mode register (ReLU) asynchronously.
// Depends on afu_pkg, afu_in_if and afu_out_if.
module activation_function_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  afu_in_if.sink     in_ch,
  afu_out_if.source  out_ch,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  // Stage numbering. Stage 0 is the input register, the last stage the result register.
  localparam int XSH    = afu_pkg::IFRAC - FRAC_BITS;
  localparam int ST_N   = 5;   // exponent n and reduced argument
  localparam int ST_R   = 6;   // remainder r
  localparam int ST_Y0  = 7;   // first polynomial step and r^2
  localparam int ST_Y   = 12;  // exp(r) finished
  localparam int ST_DS  = 13;  // divider set-up
  localparam int ST_D0  = 14;  // first quotient bit
  localparam int ST_DL  = ST_D0 + afu_pkg::QUOT_W - 1;
  localparam int ST_W   = ST_DL + 1;  // product x*sigmoid
  localparam int NSTG   = ST_W + 2;
  localparam int QW     = afu_pkg::QUOT_W;

  localparam logic signed [63:0] OUT_RND = (64'sd1 <<< XSH) >>> 1;
  localparam logic signed [63:0] OUT_HI  = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_LO  = -(64'sd1 <<< (DATA_WIDTH - 1));

  afu_pkg::mode_e mode_q;
  logic           vld_q  [NSTG];
  afu_pkg::meta_t meta_q [NSTG];
  logic signed [DATA_WIDTH-1:0] smp_q [ST_W+1];
  logic signed [31:0] x_q  [ST_W];
  logic signed [35:0] a2_q [ST_N];

  // Whole pipeline moves together; it advances unless the result register is stuck.
  logic adv;
  assign adv = !vld_q[NSTG-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= afu_pkg::MODE_RELU;
    end else if (cfg_we_i) begin
      mode_q <= afu_pkg::mode_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= in_ch.valid;
      for (int k = 1; k < NSTG; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: widen the sample to Q.28, flag the GELU tails and clamp the sigmoid
  // argument. The sigmoid exponent takes the negated input.
  logic signed [63:0] x_in;
  afu_pkg::meta_t     meta_in;
  assign x_in = 64'(in_ch.sample) <<< XSH;

  always_comb begin
    meta_in.mode = mode_q;
    meta_in.last = in_ch.last;
    meta_in.gpos = x_in >= afu_pkg::GELU_LIM_Q;
    meta_in.gneg = x_in <= -afu_pkg::GELU_LIM_Q;
  end

  // ---------------------------------------------------------------------------
  // Stages 1 to 4: GELU inner argument t2 = 2*sqrt(2/pi)*(x + k*x^3).
  logic signed [63:0] p_x2, p_kx3, p_t2;
  logic signed [60:0] p_kx2;
  logic signed [33:0] gsum;
  logic signed [35:0] x2_q, t2_q;
  logic signed [31:0] kx2_q;
  logic signed [33:0] kx3_q;

  assign p_x2  = x_q[0] * x_q[0];
  assign p_kx2 = afu_pkg::GELU_K_Q * x2_q;
  assign p_kx3 = kx2_q * x_q[2];
  assign gsum  = 34'(x_q[3]) + kx3_q;
  assign p_t2  = gsum * afu_pkg::TWO_SQRT_2_PI_Q;

  // ---------------------------------------------------------------------------
  // Stage 5: pick the exponent argument and find n = round(a*log2e).
  // Stage 6: r = a - n*ln2 with ln2 split into a high and a low part.
  logic signed [35:0] a_sel, a_q;
  logic signed [57:0] p_n;
  logic signed [8:0]  n_nx;
  logic signed [37:0] p_hi;
  logic signed [26:0] p_lo;
  logic signed [39:0] r_full;
  logic signed [8:0]  n_q  [ST_N:ST_Y];
  logic signed [29:0] r_q  [ST_R:ST_Y-1];
  logic signed [29:0] r2_q [ST_Y0:ST_Y-1];

  always_comb begin
    if (meta_q[ST_N-1].mode == afu_pkg::MODE_GELU) begin
      a_sel = afu_pkg::clamp_exp(-64'(t2_q));
    end else begin
      a_sel = a2_q[ST_N-1];
    end
  end

  assign p_n    = a_sel * afu_pkg::LOG2E_Q20;
  assign n_nx   = 9'((64'(p_n) + afu_pkg::LOG2_RND) >>> afu_pkg::LOG2_SH);
  assign p_hi   = n_q[ST_N] * afu_pkg::LN2_HI_Q;
  assign p_lo   = n_q[ST_N] * afu_pkg::LN2_LO_Q;
  assign r_full = 40'(a_q) - 40'(p_hi) - 40'(p_lo);

  // ---------------------------------------------------------------------------
  // Stages 7 to 12: exp(r) = 1 + r + r^2*P(r), Horner form, one product a stage.
  logic signed [31:0] y_q  [ST_Y0:ST_Y];
  logic signed [63:0] p_y  [ST_Y0:ST_Y];
  logic signed [31:0] y_nx [ST_Y0:ST_Y];
  logic signed [59:0] p_r2;

  assign p_r2 = r_q[ST_R] * r_q[ST_R];

  always_comb begin
    p_y[ST_Y0]  = afu_pkg::POLY_Q[0] * r_q[ST_R];
    y_nx[ST_Y0] = 32'(afu_pkg::rnd_q(p_y[ST_Y0])) + afu_pkg::POLY_Q[1];
    for (int k = ST_Y0 + 1; k < ST_Y; k++) begin
      p_y[k]  = y_q[k-1] * r_q[k-1];
      y_nx[k] = 32'(afu_pkg::rnd_q(p_y[k])) + afu_pkg::POLY_Q[k-ST_Y0+1];
    end
    p_y[ST_Y]  = y_q[ST_Y-1] * r2_q[ST_Y-1];
    y_nx[ST_Y] = 32'(afu_pkg::rnd_q(p_y[ST_Y])) + 32'(r_q[ST_Y-1]) + afu_pkg::ONE_Q;
  end

  // ---------------------------------------------------------------------------
  // Stage 13: sigmoid = 2^56 / (2^28 + y*2^n), rounded. The 2^n factor is moved
  // onto the numerator for n >= 0 and onto y for n < 0 to keep the divisor short.
  logic [30:0]        ds_y, ds_den, ds_half;
  logic [5:0]         ds_nsh;
  logic signed [9:0]  ds_sh;
  logic               ds_zero;
  logic [56:0]        ds_num;

  always_comb begin
    ds_y    = 31'(y_q[ST_Y]);
    ds_sh   = -(10'(n_q[ST_Y]));
    ds_half = '0;
    if (!n_q[ST_Y][8]) begin
      ds_zero = n_q[ST_Y] > 9'sd56;
      ds_nsh  = 6'd56 - 6'(n_q[ST_Y]);
      if (n_q[ST_Y] <= 9'sd28) begin
        ds_half = 31'(afu_pkg::ONE_Q) >> n_q[ST_Y][4:0];
      end
      ds_den  = ds_y + ds_half;
    end else begin
      // Very negative exponents make y*2^n vanish, leaving a divisor of one.
      ds_zero = 1'b0;
      ds_nsh  = 6'd56;
      ds_den  = 31'(afu_pkg::ONE_Q);
      if (ds_sh <= 10'sd30) begin
        ds_den = 31'(afu_pkg::ONE_Q) + (ds_y >> ds_sh[4:0]);
      end
    end
    ds_num = (57'd1 << ds_nsh) + 57'(ds_den >> 1);
  end

  // ---------------------------------------------------------------------------
  // Stages 14 to 42: restoring division, one quotient bit per stage.
  logic [30:0]   rem_q  [ST_DS:ST_DL];
  logic [30:0]   den_q  [ST_DS:ST_DL];
  logic [QW-1:0] nlo_q  [ST_DS:ST_DL];
  logic [QW-1:0] quo_q  [ST_DS:ST_DL];
  logic          zero_q [ST_DS:ST_DL];
  logic [31:0]   dv_t   [ST_D0:ST_DL];
  logic          dv_ge  [ST_D0:ST_DL];
  logic [30:0]   dv_rem [ST_D0:ST_DL];

  always_comb begin
    for (int k = ST_D0; k <= ST_DL; k++) begin
      dv_t[k]   = {rem_q[k-1], nlo_q[k-1][ST_DL-k]};
      dv_ge[k]  = dv_t[k] >= {1'b0, den_q[k-1]};
      dv_rem[k] = dv_ge[k] ? 31'(dv_t[k] - {1'b0, den_q[k-1]}) : dv_t[k][30:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 43: GELU multiplies x by the sigmoid; the sigmoid mode takes it as is.
  // Stage 44: round to the output format, saturate and choose by mode.
  logic [QW-1:0]      sig;
  logic signed [63:0] p_w;
  logic signed [33:0] w_nx, w_q;
  logic signed [63:0] o_ext;
  logic signed [DATA_WIDTH-1:0] o_sat, res_nx, res_q;
  logic signed [DATA_WIDTH-1:0] s_fin;
  afu_pkg::meta_t     m_fin;

  assign sig   = zero_q[ST_DL] ? '0 : quo_q[ST_DL];
  assign p_w   = x_q[ST_W-1] * signed'({1'b0, sig});
  assign w_nx  = (meta_q[ST_W-1].mode == afu_pkg::MODE_GELU) ?
                 34'(afu_pkg::rnd_q(p_w)) : 34'(sig);
  assign o_ext = (64'(w_q) + OUT_RND) >>> XSH;
  assign m_fin = meta_q[ST_W];
  assign s_fin = smp_q[ST_W];

  always_comb begin
    if (o_ext > OUT_HI) begin
      o_sat = DATA_WIDTH'(OUT_HI);
    end else if (o_ext < OUT_LO) begin
      o_sat = DATA_WIDTH'(OUT_LO);
    end else begin
      o_sat = DATA_WIDTH'(o_ext);
    end
    case (m_fin.mode)
      afu_pkg::MODE_RELU: begin
        res_nx = (s_fin > 0) ? s_fin : '0;
      end
      afu_pkg::MODE_GELU: begin
        // Beyond |x| = 8 the tails are x and zero to well within an output LSB.
        if (m_fin.gpos) begin
          res_nx = s_fin;
        end else if (m_fin.gneg) begin
          res_nx = '0;
        end else begin
          res_nx = o_sat;
        end
      end
      afu_pkg::MODE_SIGMOID: begin
        res_nx = o_sat;
      end
      default: begin
        res_nx = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Payload registers; they carry no reset.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[0] <= meta_in;
      smp_q[0]  <= in_ch.sample;
      x_q[0]    <= x_in[31:0];
      a2_q[0]   <= afu_pkg::clamp_exp(-x_in);
      for (int k = 1; k < NSTG; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
      for (int k = 1; k <= ST_W; k++) begin
        smp_q[k] <= smp_q[k-1];
      end
      for (int k = 1; k < ST_W; k++) begin
        x_q[k] <= x_q[k-1];
      end
      for (int k = 1; k < ST_N; k++) begin
        a2_q[k] <= a2_q[k-1];
      end

      x2_q  <= 36'(afu_pkg::rnd_q(p_x2));
      kx2_q <= 32'(afu_pkg::rnd_q(64'(p_kx2)));
      kx3_q <= 34'(afu_pkg::rnd_q(p_kx3));
      t2_q  <= 36'(afu_pkg::rnd_q(p_t2));

      a_q       <= a_sel;
      n_q[ST_N] <= n_nx;
      for (int k = ST_N + 1; k <= ST_Y; k++) begin
        n_q[k] <= n_q[k-1];
      end
      r_q[ST_R] <= r_full[29:0];
      for (int k = ST_R + 1; k < ST_Y; k++) begin
        r_q[k] <= r_q[k-1];
      end
      r2_q[ST_Y0] <= 30'(afu_pkg::rnd_q(64'(p_r2)));
      for (int k = ST_Y0 + 1; k < ST_Y; k++) begin
        r2_q[k] <= r2_q[k-1];
      end
      for (int k = ST_Y0; k <= ST_Y; k++) begin
        y_q[k] <= y_nx[k];
      end

      rem_q[ST_DS]  <= 31'(ds_num >> QW);
      nlo_q[ST_DS]  <= ds_num[QW-1:0];
      den_q[ST_DS]  <= ds_den;
      quo_q[ST_DS]  <= '0;
      zero_q[ST_DS] <= ds_zero;
      for (int k = ST_D0; k <= ST_DL; k++) begin
        rem_q[k]  <= dv_rem[k];
        quo_q[k]  <= {quo_q[k-1][QW-2:0], dv_ge[k]};
        den_q[k]  <= den_q[k-1];
        nlo_q[k]  <= nlo_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end

      w_q   <= w_nx;
      res_q <= res_nx;
    end
  end

  assign out_ch.valid    = vld_q[NSTG-1];
  assign out_ch.result   = res_q;
  assign out_ch.last_out = meta_q[NSTG-1].last;

endmodule

### hdl/afu_checker.sv
// Port-level checker for the activation function unit, bound to the top level.
// Depends on activation_function_unit_defines.svh and activation_function_unit.
`include "activation_function_unit_defines.svh"

module afu_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] result_i
);

  // With an empty result register the unit always takes a new item.
  `AFU_ASSERT(a_ready_when_empty, !out_valid_i |-> in_ready_i, "input blocked while output empty")
  // A held result stalls the whole pipeline, so no item may enter.
  `AFU_ASSERT(a_stall_blocks_input, out_valid_i && !out_ready_i |-> !in_ready_i, "input taken during stall")
  // A stalled result keeps its value.
  `AFU_ASSERT(a_result_stable, out_valid_i && !out_ready_i |=> $stable(result_i), "result changed while stalled")
  // No result leaves the cycle after reset is seen.
  `AFU_ASSERT_ALWAYS(a_reset_clears, !rst_ni |=> !out_valid_i, "output valid after reset")

endmodule

bind activation_function_unit afu_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_afu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_ch.valid),
  .in_ready_i (in_ch.ready),
  .out_valid_i(out_ch.valid),
  .out_ready_i(out_ch.ready),
  .result_i   (out_ch.result)
);
